@@ src/mss_pkg.sv @@
// ----------------------------------------------------------------------------
// Material sorter sequencer package
// Phase and material codes, field widths and register map constants.
// ----------------------------------------------------------------------------
package mss_pkg;

  localparam int PhaseW    = 3;
  localparam int MaterialW = 3;
  localparam int DirW      = 2;
  localparam int DutyW     = 8;
  localparam int PaddrW    = 3;
  localparam int PdataW    = 32;

  typedef logic [PhaseW-1:0]    phase_t;
  typedef logic [MaterialW-1:0] material_t;
  typedef logic [DirW-1:0]      dir_t;
  typedef logic [DutyW-1:0]     duty_t;
  typedef logic [PaddrW-1:0]    paddr_t;
  typedef logic [PdataW-1:0]    pdata_t;

  localparam phase_t PH_SEEK       = 3'd0;
  localparam phase_t PH_RETURN     = 3'd1;
  localparam phase_t PH_WAIT_ITEM  = 3'd2;
  localparam phase_t PH_WAIT_START = 3'd3;
  localparam phase_t PH_CLASSIFY   = 3'd4;
  localparam phase_t PH_MOVE_CAN   = 3'd5;
  localparam phase_t PH_MOVE_GLASS = 3'd6;
  localparam phase_t PH_DEPOSIT    = 3'd7;

  localparam material_t MAT_NONE    = 3'd0;
  localparam material_t MAT_CAN     = 3'd1;
  localparam material_t MAT_GLASS   = 3'd2;
  localparam material_t MAT_PET     = 3'd3;
  localparam material_t MAT_UNKNOWN = 3'd4;

  localparam dir_t DIR_STOP = 2'd0;
  localparam dir_t DIR_ONE  = 2'd1;
  localparam dir_t DIR_TWO  = 2'd2;

  localparam duty_t DUTY_RESET = 8'd25;

  localparam logic REG_MOTOR_DUTY = 1'b0;

endpackage

@@ src/mss_in_if.sv @@
// ----------------------------------------------------------------------------
// Material sorter input channel
// One item carries one sample of the sensor and button pin levels.
// ----------------------------------------------------------------------------
interface mss_in_if;
  logic valid;
  logic ready;
  logic metal_sensor;
  logic pet_sensor_n;
  logic glass_sensor_n;
  logic centre_pos_n;
  logic can_pos_n;
  logic glass_pos_n;
  logic start_button;
  logic exit_sensor_n;

  modport source (
    output valid, metal_sensor, pet_sensor_n, glass_sensor_n, centre_pos_n,
           can_pos_n, glass_pos_n, start_button, exit_sensor_n,
    input  ready
  );

  modport sink (
    input  valid, metal_sensor, pet_sensor_n, glass_sensor_n, centre_pos_n,
           can_pos_n, glass_pos_n, start_button, exit_sensor_n,
    output ready
  );
endinterface

@@ src/mss_out_if.sv @@
// ----------------------------------------------------------------------------
// Material sorter result channel
// One item carries the motor, ramp and status outputs of one tick.
// ----------------------------------------------------------------------------
interface mss_out_if;
  import mss_pkg::*;

  logic      valid;
  logic      ready;
  duty_t     motor_drive;
  dir_t      motor_dir;
  logic      ramp_raised;
  phase_t    phase;
  material_t material;

  modport source (
    output valid, motor_drive, motor_dir, ramp_raised, phase, material,
    input  ready
  );

  modport sink (
    input  valid, motor_drive, motor_dir, ramp_raised, phase, material,
    output ready
  );
endinterface

@@ src/material_sorter_sequencer.sv @@
// ----------------------------------------------------------------------------
// Material sorter sequencer
// Homes the ramp, classifies an item and drives it to its chute, one pin
// sample per item.
//
//   Port     Role    Content
//   in_ch    sink    one sample of the eight sensor and button pins
//   out_ch   source  motor duty, direction, ramp, phase and material
//   APB      slave   motor_duty register at byte address 0
//
// The transition logic sits between the state registers and the result
// register, and a new item is taken every cycle in which the result
// register is empty or being drained.
// Reset (rst_n low, synchronous) sets the homing seek phase, no material,
// ramp down and a duty of 25.
// ----------------------------------------------------------------------------
module material_sorter_sequencer (
  input  logic            clk,
  input  logic            rst_n,
  mss_in_if.sink          in_ch,
  mss_out_if.source       out_ch,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  mss_pkg::paddr_t paddr,
  input  mss_pkg::pdata_t pwdata,
  output mss_pkg::pdata_t prdata,
  output logic            pready
);
  import mss_pkg::*;

  duty_t     duty_r;
  phase_t    phase_r, phase_nxt;
  material_t material_r, material_nxt;
  logic      ramp_r, ramp_nxt;
  dir_t      dir_nxt;
  logic      out_valid_r;
  duty_t     out_drive_r;
  dir_t      out_dir_r;
  logic      in_take;
  logic      metal, pet, glass, at_centre, at_can, at_glass, start, leaving, item;

  assign pready = 1'b1;
  assign prdata = (paddr[PaddrW-1] == REG_MOTOR_DUTY) ?
                  {{(PdataW-DutyW){1'b0}}, duty_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_r <= DUTY_RESET;
    end else if (psel && penable && pwrite && paddr[PaddrW-1] == REG_MOTOR_DUTY) begin
      duty_r <= pwdata[DutyW-1:0];
    end
  end

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_take     = in_ch.valid && in_ch.ready;

  assign metal     = in_ch.metal_sensor;
  assign pet       = !in_ch.pet_sensor_n;
  assign glass     = !in_ch.glass_sensor_n;
  assign at_centre = !in_ch.centre_pos_n;
  assign at_can    = !in_ch.can_pos_n;
  assign at_glass  = !in_ch.glass_pos_n;
  assign start     = in_ch.start_button;
  assign leaving   = !in_ch.exit_sensor_n;
  assign item      = pet || glass || metal;

  always_comb begin
    phase_nxt    = phase_r;
    material_nxt = material_r;
    ramp_nxt     = ramp_r;
    dir_nxt      = DIR_STOP;
    case (phase_r)
      PH_SEEK: begin
        if (!at_centre && !at_glass) begin
          dir_nxt = DIR_ONE;
        end else if (at_glass && !at_centre && !at_can) begin
          dir_nxt   = DIR_TWO;
          phase_nxt = PH_RETURN;
        end else begin
          phase_nxt = PH_WAIT_ITEM;
        end
      end
      PH_RETURN: begin
        if (!at_centre) begin
          dir_nxt = DIR_TWO;
        end else begin
          phase_nxt = PH_WAIT_ITEM;
        end
      end
      PH_WAIT_ITEM: begin
        if (item) begin
          phase_nxt = PH_WAIT_START;
        end
      end
      PH_WAIT_START: begin
        if (start) begin
          phase_nxt = PH_CLASSIFY;
        end
      end
      PH_CLASSIFY: begin
        if (item) begin
          ramp_nxt  = 1'b1;
          phase_nxt = PH_DEPOSIT;
          if (metal && glass && pet) begin
            material_nxt = MAT_CAN;
            if (!at_can) begin
              dir_nxt   = DIR_TWO;
              ramp_nxt  = ramp_r;
              phase_nxt = PH_MOVE_CAN;
            end
          end else if (glass && pet) begin
            material_nxt = MAT_GLASS;
            if (!at_glass) begin
              dir_nxt   = DIR_ONE;
              ramp_nxt  = ramp_r;
              phase_nxt = PH_MOVE_GLASS;
            end
          end else if (pet && !glass && !metal) begin
            material_nxt = MAT_PET;
          end else begin
            material_nxt = MAT_UNKNOWN;
          end
        end
      end
      PH_MOVE_CAN: begin
        if (!at_can) begin
          dir_nxt = DIR_TWO;
        end else begin
          ramp_nxt  = 1'b1;
          phase_nxt = PH_DEPOSIT;
        end
      end
      PH_MOVE_GLASS: begin
        if (!at_glass) begin
          dir_nxt = DIR_ONE;
        end else begin
          ramp_nxt  = 1'b1;
          phase_nxt = PH_DEPOSIT;
        end
      end
      PH_DEPOSIT: begin
        ramp_nxt = 1'b1;
        if (leaving) begin
          ramp_nxt     = 1'b0;
          material_nxt = MAT_NONE;
          phase_nxt    = PH_SEEK;
        end
      end
      default: begin
        phase_nxt = PH_SEEK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SEEK;
      material_r  <= MAT_NONE;
      ramp_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        phase_r     <= phase_nxt;
        material_r  <= material_nxt;
        ramp_r      <= ramp_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      out_dir_r   <= dir_nxt;
      out_drive_r <= (dir_nxt != DIR_STOP) ? duty_r : '0;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.motor_drive = out_drive_r;
  assign out_ch.motor_dir   = out_dir_r;
  assign out_ch.ramp_raised = ramp_r;
  assign out_ch.phase       = phase_r;
  assign out_ch.material    = material_r;

endmodule
